@@ src/fpd_pkg.sv @@
// Package for the five-point diffusion filter: beat types, register indexes
// and fixed-point constants. No dependencies.
package fpd_pkg;

  localparam int SampleBits  = 16;
  localparam int FwBits      = 12;
  localparam int FhBits      = 13;
  localparam int MinDim      = 3;
  localparam int HeightLimit = 4096;

  // 6*centre + four neighbours + rounding term stays below 2^20.
  localparam int SumBits    = 20;
  localparam int RecipBits  = 20;
  localparam int RecipShift = 23;
  // ceil(2^23 / 10): floor(n * Recip10 / 2^23) equals n / 10 for n below 2^22.
  localparam logic [RecipBits-1:0] Recip10 = 20'd838861;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    op_e                   operation;
    logic [SampleBits-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [SampleBits-1:0] filtered;
    logic                  frame_last;
  } out_beat_t;

  // Control of the item held in the compute stage.
  typedef struct packed {
    logic drain;  // drain tick: the centre value goes out as is
    logic pass;   // border pixel: the centre value goes out as is
    logic last;   // final pixel of the frame
  } kern_ctl_t;

endpackage

@@ src/five_point_diffusion_filter_unit.sv @@
// Top level of the five-point diffusion filter: counters, configuration and
// the compute stage. Depends on fpd_pkg, fpd_line_buffer and fpd_kernel.
//
// Usage. Pixels of a frame enter in raster order on the input channel, one
// beat each, with operation set to pixel. Each interior pixel leaves as
// (6*centre + up + down + left + right + 5) / 10; pixels of the first and
// last row and column leave unchanged. Row r is delivered while row r+1
// enters, so the first row yields no output beats. After the frame, send
// frame_width beats with operation set to drain; they flush the last row and
// the final one carries frame_last. A drain beat before the frame is complete,
// or a pixel beat while the last row drains, is consumed and yields nothing.
// Throughput is one beat per cycle while the receiver keeps up. The row store
// reads and the beat's control are registered in the compute stage when the
// beat is accepted, and the kernel sum and the reciprocal multiply feed the
// output register as that stage moves on. If the
// receiver stalls, the output register and the compute stage fill, and input
// ready drops until the output beat is taken. Reset clears the counters and
// loads frame_width 1920 and frame_height 1080; the row stores are not
// cleared; every entry whose value is used in a normal frame is written first.
// Write the configuration only while the block is idle.
module five_point_diffusion_filter_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  fpd_pkg::cfg_index_e          cfg_index_i,
  input  logic [fpd_pkg::FhBits-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fpd_pkg::in_beat_t            in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fpd_pkg::out_beat_t           out_o
);
  import fpd_pkg::*;

  localparam int CntW = $clog2(MAX_WIDTH);
  localparam int WidW = $clog2(MAX_WIDTH + 1);
  localparam int LW   = (WidW > FwBits) ? WidW : FwBits;

  logic [FwBits-1:0]     frame_width_q;
  logic [FhBits-1:0]     frame_height_q;
  logic [CntW-1:0]       col_q;
  logic [FhBits-1:0]     row_q;
  logic                  s1_valid_q;
  kern_ctl_t             ctl_q;
  logic [SampleBits-1:0] px_q;

  logic [LW-1:0]         fw_ext, used_w;
  logic [FhBits-1:0]     used_h;
  logic                  drain, tick, row_end, match, emit, accept;
  logic                  s1_ready, s1_adv;
  logic [SampleBits-1:0] up, centre, right;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FwBits'(1920);
      frame_height_q <= FhBits'(1080);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FwBits-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Out-of-range sizes saturate to the nearest bound.
  always_comb begin
    fw_ext = LW'(frame_width_q);
    if (fw_ext < LW'(MinDim)) begin
      used_w = LW'(MinDim);
    end else if (fw_ext > LW'(MAX_WIDTH)) begin
      used_w = LW'(MAX_WIDTH);
    end else begin
      used_w = fw_ext;
    end
    if (frame_height_q < FhBits'(MinDim)) begin
      used_h = FhBits'(MinDim);
    end else if (frame_height_q > FhBits'(HeightLimit)) begin
      used_h = FhBits'(HeightLimit);
    end else begin
      used_h = frame_height_q;
    end
  end

  // The row count reaching the frame height marks the drain phase.
  assign drain   = row_q >= used_h;
  assign tick    = in_i.operation == OP_DRAIN;
  assign row_end = (LW'(col_q) + LW'(1)) >= used_w;
  assign match   = tick == drain;
  // The first row only fills the newer row store.
  assign emit    = match && (drain || row_q != '0);

  // A new beat enters whenever the compute stage is empty or moving on.
  assign s1_adv     = s1_valid_q && s1_ready;
  assign in_ready_o = !s1_valid_q || s1_ready;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= emit;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (accept && match) begin
        if (row_end) begin
          col_q <= '0;
          row_q <= drain ? '0 : row_q + FhBits'(1);
        end else begin
          col_q <= col_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      ctl_q.drain <= drain;
      ctl_q.pass  <= (row_q == FhBits'(1)) || (col_q == '0) || row_end;
      ctl_q.last  <= drain && row_end;
      px_q        <= in_i.sample;
    end
  end

  fpd_line_buffer #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buffer (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .col_i      (col_q),
    .wr_newer_i (accept && match && !drain),
    .px_i       (in_i.sample),
    .commit_i   (s1_adv && !ctl_q.drain),
    .up_o       (up),
    .centre_o   (centre),
    .right_o    (right)
  );

  fpd_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .ctl_i       (ctl_q),
    .px_i        (px_q),
    .up_i        (up),
    .centre_i    (centre),
    .right_i     (right),
    .s1_ready_o  (s1_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // A drain beat taken during the drain phase always yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && tick && drain |=> s1_valid_q)
    else $error("drain beat produced no result");

  // A beat that yields nothing leaves the compute stage empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !emit |=> !s1_valid_q)
    else $error("result invented for a silent beat");

  // Ignored beats do not move the counters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !match |=> $stable(col_q) && $stable(row_q))
    else $error("ignored beat moved the counters");

  // The final drain beat rewinds to the start of the next frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && tick && drain && row_end |=> col_q == '0 && row_q == '0)
    else $error("counters not rewound after frame end");

endmodule

@@ src/fpd_line_buffer.sv @@
// Row stores of the diffusion filter: the older and the newer row, each one
// synchronous memory with registered read data. Depends on fpd_pkg.
module fpd_line_buffer #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]        col_i,
  input  logic                                wr_newer_i,
  input  logic [fpd_pkg::SampleBits-1:0]      px_i,
  input  logic                                commit_i,
  output logic [fpd_pkg::SampleBits-1:0]      up_o,
  output logic [fpd_pkg::SampleBits-1:0]      centre_o,
  output logic [fpd_pkg::SampleBits-1:0]      right_o
);
  import fpd_pkg::*;

  localparam int CntW = $clog2(MAX_WIDTH);

  logic [SampleBits-1:0] older_mem [MAX_WIDTH];
  logic [SampleBits-1:0] newer_mem [MAX_WIDTH];

  logic [CntW-1:0]       col_q;
  logic [CntW-1:0]       right_addr;
  logic [SampleBits-1:0] up_q, centre_q, right_q;

  // At the last column the right-hand read goes past it (wrapping at MAX_WIDTH); that value is never used.
  assign right_addr = col_i + CntW'(1);

  // Reads see the contents before a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_q     <= older_mem[col_i];
      centre_q <= newer_mem[col_i];
      right_q  <= newer_mem[right_addr];
      col_q    <= col_i;
    end
    if (wr_newer_i) begin
      newer_mem[col_i] <= px_i;
    end
  end

  // The centre of the row below becomes the row above once the item retires.
  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      older_mem[col_q] <= centre_q;
    end
  end

  assign up_o     = up_q;
  assign centre_o = centre_q;
  assign right_o  = right_q;

endmodule

@@ src/fpd_kernel.sv @@
// Five-point kernel and output register of the diffusion filter, with the
// left-neighbour register. Depends on fpd_pkg.
module fpd_kernel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s1_valid_i,
  input  fpd_pkg::kern_ctl_t             ctl_i,
  input  logic [fpd_pkg::SampleBits-1:0] px_i,
  input  logic [fpd_pkg::SampleBits-1:0] up_i,
  input  logic [fpd_pkg::SampleBits-1:0] centre_i,
  input  logic [fpd_pkg::SampleBits-1:0] right_i,
  output logic                           s1_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output fpd_pkg::out_beat_t             out_o
);
  import fpd_pkg::*;

  localparam int ProdBits = SumBits + RecipBits;

  logic [SampleBits-1:0] left_q;
  logic                  out_valid_q;
  out_beat_t             out_q;
  logic [SumBits-1:0]    sum;
  logic [ProdBits-1:0]   prod;
  logic [SampleBits-1:0] result;
  logic                  advance;

  always_comb begin
    sum = (SumBits'(centre_i) << 2) + (SumBits'(centre_i) << 1)
        + SumBits'(up_i) + SumBits'(px_i) + SumBits'(left_q) + SumBits'(right_i)
        + SumBits'(5);
    prod = ProdBits'(sum) * ProdBits'(Recip10);
    if (ctl_i.drain || ctl_i.pass) begin
      result = centre_i;
    end else begin
      result = prod[RecipShift +: SampleBits];
    end
  end

  assign s1_ready_o = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_i && s1_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        left_q      <= centre_i;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.filtered   <= result;
      out_q.frame_last <= ctl_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
